/* rtl/q4_q8_block_matvec_row_accumulator_defines.svh */
// Assertion macros used by the row accumulator controller.
`ifndef Q4_Q8_BLOCK_MATVEC_ROW_ACCUMULATOR_DEFINES_SVH
`define Q4_Q8_BLOCK_MATVEC_ROW_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define Q4Q8_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define Q4Q8_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/q4q8_pkg.sv */
// Types and constants for the Q4 x Q8 block row accumulator.
package q4q8_pkg;

    localparam int C_NIBBLE_OFFSET = 8;
    localparam int C_Q_FRAC        = 24;

    localparam logic signed [15:0] C_SUM_MAX = 16'sh7fff;
    localparam logic signed [15:0] C_SUM_MIN = 16'sh8000;
    localparam logic signed [63:0] C_ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] C_ACC_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [7:0]        weight_byte;
        logic signed [7:0] act_low;
        logic signed [7:0] act_high;
        logic [31:0]       weight_scale;
        logic [31:0]       act_scale;
        logic              last_in_block;
        logic              last_in_row;
    } t_in_req;

    typedef struct packed {
        logic signed [63:0] row_value;
        logic [15:0]        row_index;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_TERM,
        ST_ACC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic take;
        logic mul_hi;
        logic mul_lo;
        logic term;
        logic acc;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic in_end;
        logic end_row;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/q4q8_dp.sv */
// Datapath: block sum, scale multiplies, saturating row accumulator, result register.
module q4q8_dp
    import q4q8_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_req  i_in_req,
    input  logic     i_out_stall,
    input  logic     i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_dp_cmd  i_cmd,
    output t_dp_sts  o_sts,
    output logic     o_out_valid,
    output t_out_req o_out_req
);

    logic signed [15:0] r_blk_sum, n_blk_sum;
    logic [63:0]        r_prod;
    logic               r_end_row;
    logic signed [48:0] r_mh;
    logic signed [48:0] r_ml;
    logic signed [63:0] r_term;
    logic signed [63:0] r_acc;
    logic [15:0]        r_row_cnt;
    logic [15:0]        r_first_row;
    logic               r_out_valid;
    t_out_req           r_out_req;

    logic signed [4:0]  w_lo_w, w_hi_w;
    logic signed [12:0] w_p_lo, w_p_hi;
    logic signed [17:0] w_sum;
    logic signed [32:0] w_mul_op;
    logic signed [48:0] w_mul;
    logic signed [63:0] w_term;
    logic [64:0]        w_acc_sum;
    logic signed [63:0] w_acc_sat;

    always_comb begin
        w_lo_w = $signed({1'b0, i_in_req.weight_byte[3:0]}) - 5'(C_NIBBLE_OFFSET);
        w_hi_w = $signed({1'b0, i_in_req.weight_byte[7:4]}) - 5'(C_NIBBLE_OFFSET);
        w_p_lo = w_lo_w * i_in_req.act_low;
        w_p_hi = w_hi_w * i_in_req.act_high;
        w_sum  = 18'(r_blk_sum) + 18'(w_p_lo) + 18'(w_p_hi);
        if (w_sum > 18'(C_SUM_MAX)) begin
            n_blk_sum = C_SUM_MAX;
        end else if (w_sum < 18'(C_SUM_MIN)) begin
            n_blk_sum = C_SUM_MIN;
        end else begin
            n_blk_sum = w_sum[15:0];
        end
    end

    // One shared 16x33 signed multiplier for both halves of the scale product.
    assign w_mul_op = $signed({1'b0, i_cmd.mul_hi ? r_prod[63:32] : r_prod[31:0]});
    assign w_mul    = r_blk_sum * w_mul_op;

    // floor(s * P / 2^24) = s*Ph*2^8 + floor(s*Pl / 2^24)
    assign w_term = (64'(r_mh) <<< 8) + 64'(r_ml >>> C_Q_FRAC);

    always_comb begin
        w_acc_sum = {r_acc[63], r_acc} + {r_term[63], r_term};
        if (w_acc_sum[64] != w_acc_sum[63]) begin
            w_acc_sat = w_acc_sum[64] ? C_ACC_MIN : C_ACC_MAX;
        end else begin
            w_acc_sat = w_acc_sum[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_sum   <= '0;
            r_acc       <= '0;
            r_row_cnt   <= '0;
            r_first_row <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_first_row <= i_cfg_data;
            end
            if (i_cmd.take) begin
                r_blk_sum <= n_blk_sum;
            end else if (i_cmd.acc) begin
                r_blk_sum <= '0;
            end
            if (i_cmd.acc) begin
                r_acc <= w_acc_sat;
            end else if (i_cmd.load_out) begin
                r_acc <= '0;
            end
            if (i_cmd.load_out) begin
                r_row_cnt   <= r_row_cnt + 16'd1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_prod    <= 64'(i_in_req.weight_scale) * 64'(i_in_req.act_scale);
            r_end_row <= i_in_req.last_in_row;
        end
        if (i_cmd.mul_hi) begin
            r_mh <= w_mul;
        end
        if (i_cmd.mul_lo) begin
            r_ml <= w_mul;
        end
        if (i_cmd.term) begin
            r_term <= w_term;
        end
        if (i_cmd.load_out) begin
            r_out_req.row_value <= r_acc;
            r_out_req.row_index <= r_first_row + r_row_cnt;
        end
    end

    assign o_sts.in_end   = i_in_req.last_in_block | i_in_req.last_in_row;
    assign o_sts.end_row  = r_end_row;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_req      = r_out_req;

endmodule

/* rtl/q4q8_ctrl.sv */
// Controller: sequences block close and row emit over the datapath.
module q4q8_ctrl
    import q4q8_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

`include "q4_q8_block_matvec_row_accumulator_defines.svh"

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_sts.in_end) begin
                    n_state = ST_MUL_HI;
                end
            end
            ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_TERM;
            end
            ST_TERM: begin
                o_cmd.term = 1'b1;
                n_state    = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.end_row ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                o_cmd.load_out = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    `Q4Q8_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(o_cmd), "more than one datapath command")
    `Q4Q8_ASSERT_NEXT(a_close_seq, o_cmd.take && i_sts.in_end, r_state == ST_MUL_HI,
                      "block close did not start the multiply sequence")
    `Q4Q8_ASSERT_NEXT(a_emit_done, o_cmd.load_out, r_state == ST_IDLE && !o_in_stall,
                      "not idle after loading a result")

endmodule

/* rtl/q4_q8_block_matvec_row_accumulator.sv */
// Top level of the Q4 x Q8 block-quantized row dot product accumulator.
//
// Input channel (i_in_valid / o_in_stall / i_in_req): one packed weight byte
// with its two int8 activations, the Q8.24 block scales and the block/row
// end flags. Output channel (o_out_valid / i_out_stall / o_out_req): one
// request per finished row, the saturated Q.24 row value and the row index.
// Config: i_cfg_we / i_cfg_data set the index reported for the first row.
// A byte that does not close a block leaves the input free; the next one can be
// taken in the following cycle. A byte that closes a block starts the scale
// product sequence (one 32x32 multiply, two passes of a shared 16x33
// multiplier, a term add and the saturating accumulate), and input stalls
// until it ends. A row-closing byte adds an emit state that waits for a free output register and then loads the result.
// The result sits in an output register, so input keeps flowing while it
// waits; only a second row end stalls until the first result is taken.
// Reset (synchronous, active low) clears the block sum, the accumulator,
// the row counter, the first-row index and the output valid.
module q4_q8_block_matvec_row_accumulator
    import q4q8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_req    o_out_req,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    q4q8_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    q4q8_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule
